@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the peak/trough detector RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising clock edge, masked while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/ptd_pkg.sv @@
// Shared types and constants of the peak/trough detector.
// No dependencies; imported by ptd_if, ptd_front, ptd_queue and peak_trough_detector.
package ptd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int THRESH_BITS = 16;
   localparam int CMP_BITS    = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   localparam logic EVENT_PEAK   = 1'b0;
   localparam logic EVENT_TROUGH = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [INDEX_BITS-1:0]         index_type;
   typedef logic [THRESH_BITS-1:0]        thresh_type;
   typedef logic signed [CMP_BITS-1:0]    cmp_type;

   typedef enum logic [2:0] {
      MODE_UNDECIDED   = 3'b001,
      MODE_SEEK_PEAK   = 3'b010,
      MODE_SEEK_TROUGH = 3'b100
   } mode_type;

   typedef struct packed {
      logic       kind;
      index_type  index;
      sample_type value;
      index_type  count;
   } result_type;

endpackage

@@ hw/rtl/ptd_if.sv @@
// Handshake channels of the peak/trough detector: samples, results, threshold.
// Depends on ptd_pkg.
interface ptd_req_if import ptd_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last_in_set;
   modport source (output valid, sample, last_in_set, input ready);
   modport sink   (input valid, sample, last_in_set, output ready);
endinterface

interface ptd_rsp_if import ptd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       event_kind;
   index_type  event_index;
   sample_type event_value;
   index_type  event_count;
   modport source (output valid, event_kind, event_index, event_value, event_count,
                   input ready);
   modport sink   (input valid, event_kind, event_index, event_value, event_count,
                   output ready);
endinterface

interface ptd_csr_if import ptd_pkg::*; ();
   logic       valid;
   logic       ready;
   thresh_type threshold;
   modport source (output valid, threshold, input ready);
   modport sink   (input valid, threshold, output ready);
endinterface

@@ hw/rtl/ptd_front.sv @@
// Front end: threshold register, direction state and held extremes; classifies each item.
// Depends on ptd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptd_front import ptd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  thresh_type csr_data,
   input  logic       req_valid,
   input  sample_type req_sample,
   input  logic       req_last,
   output logic       req_ready,
   input  logic       queue_space,
   output logic       push,
   output result_type evt
);

   thresh_type thresh_ff;
   mode_type   mode_ff, mode_in;
   sample_type max_value_ff, max_value_in, min_value_ff, min_value_in;
   index_type  max_index_ff, max_index_in, min_index_ff, min_index_in;
   index_type  index_ff, index_in;
   index_type  peak_count_ff, peak_count_in, trough_count_ff, trough_count_in;

   logic       accept, first, emit;
   sample_type cur_max, cur_min;
   index_type  cur_max_idx, cur_min_idx;
   cmp_type    s_x, e_x, max_x, min_x;
   logic       peak_hit, trough_hit, rising, falling;

   function automatic index_type sat_inc(input index_type v);
      return (v == INDEX_MAX) ? v : INDEX_BITS'(v + 1'b1);
   endfunction

   assign req_ready = queue_space;
   assign accept    = req_valid && req_ready;
   assign push      = accept && emit;

   always_comb begin
      first       = (index_ff == '0);
      cur_max     = first ? req_sample : max_value_ff;
      cur_min     = first ? req_sample : min_value_ff;
      cur_max_idx = first ? '0 : max_index_ff;
      cur_min_idx = first ? '0 : min_index_ff;

      s_x   = $signed({{(CMP_BITS-SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}}, req_sample});
      e_x   = $signed({{(CMP_BITS-THRESH_BITS){1'b0}}, thresh_ff});
      max_x = $signed({{(CMP_BITS-SAMPLE_BITS){cur_max[SAMPLE_BITS-1]}}, cur_max});
      min_x = $signed({{(CMP_BITS-SAMPLE_BITS){cur_min[SAMPLE_BITS-1]}}, cur_min});

      peak_hit   = max_x >= (s_x + e_x);
      trough_hit = s_x >= (min_x + e_x);
      rising     = cur_max <= req_sample;
      falling    = req_sample <= cur_min;

      mode_in         = mode_ff;
      max_value_in    = cur_max;
      max_index_in    = cur_max_idx;
      min_value_in    = cur_min;
      min_index_in    = cur_min_idx;
      peak_count_in   = peak_count_ff;
      trough_count_in = trough_count_ff;
      emit            = 1'b0;
      evt.kind        = EVENT_PEAK;
      evt.index       = cur_max_idx;
      evt.value       = cur_max;
      evt.count       = sat_inc(peak_count_ff);

      case (mode_ff)
         MODE_SEEK_PEAK: begin
            if (rising) begin
               max_value_in = req_sample;
               max_index_in = index_ff;
            end else if (peak_hit) begin
               emit          = 1'b1;
               peak_count_in = sat_inc(peak_count_ff);
               min_value_in  = req_sample;
               min_index_in  = index_ff;
               mode_in       = MODE_SEEK_TROUGH;
            end
         end
         MODE_SEEK_TROUGH: begin
            evt.kind  = EVENT_TROUGH;
            evt.index = cur_min_idx;
            evt.value = cur_min;
            evt.count = sat_inc(trough_count_ff);
            if (falling) begin
               min_value_in = req_sample;
               min_index_in = index_ff;
            end else if (trough_hit) begin
               emit            = 1'b1;
               trough_count_in = sat_inc(trough_count_ff);
               max_value_in    = req_sample;
               max_index_in    = index_ff;
               mode_in         = MODE_SEEK_PEAK;
            end
         end
         default: begin
            if (peak_hit) begin
               mode_in = MODE_SEEK_TROUGH;
            end else if (trough_hit) begin
               mode_in = MODE_SEEK_PEAK;
            end else begin
               mode_in = MODE_UNDECIDED;
            end
            if (rising) begin
               max_value_in = req_sample;
               max_index_in = index_ff;
            end else if (falling) begin
               min_value_in = req_sample;
               min_index_in = index_ff;
            end
         end
      endcase

      index_in = sat_inc(index_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_write) begin
         thresh_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_UNDECIDED;
         index_ff        <= '0;
         peak_count_ff   <= '0;
         trough_count_ff <= '0;
      end else if (accept) begin
         if (req_last) begin
            mode_ff         <= MODE_UNDECIDED;
            index_ff        <= '0;
            peak_count_ff   <= '0;
            trough_count_ff <= '0;
         end else begin
            mode_ff         <= mode_in;
            index_ff        <= index_in;
            peak_count_ff   <= peak_count_in;
            trough_count_ff <= trough_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         max_value_ff <= max_value_in;
         max_index_ff <= max_index_in;
         min_value_ff <= min_value_in;
         min_index_ff <= min_index_in;
      end
   end

   `ASSERT_RST(a_push_needs_direction, clock, reset, push |-> (mode_ff != MODE_UNDECIDED), "event raised while direction undecided")
   `ASSERT_RST(a_last_clears, clock, reset, (accept && req_last) |=> (index_ff == '0 && mode_ff == MODE_UNDECIDED), "state not cleared after last item of set")
   `ASSERT_RST(a_count_nonzero, clock, reset, push |-> (evt.count != '0), "event count is zero")

endmodule

@@ hw/rtl/ptd_queue.sv @@
// Back end: short result queue whose head drives the result channel.
// Depends on ptd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptd_queue import ptd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       rsp_valid,
   output result_type rsp_data,
   input  logic       rsp_ready
);

   localparam logic [COUNT_BITS-1:0] QUEUE_FULL = COUNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);

   result_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space     = (count_ff != QUEUE_FULL) || pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      case ({push, pop})
         2'b10:   count_in = COUNT_BITS'(count_ff + 1'b1);
         2'b01:   count_in = COUNT_BITS'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_RST(a_count_bound, clock, reset, count_ff <= QUEUE_FULL, "queue count above depth")
   `ASSERT_RST(a_no_overflow, clock, reset, push |-> (count_ff != QUEUE_FULL || pop), "push when full")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (count_ff == '0), "queue not empty after reset")

endmodule

@@ hw/rtl/peak_trough_detector.sv @@
// Peak and trough detector with hysteresis: takes one signed sample per item and
// reports each confirmed peak or trough with its index, value and running count.
// The block accepts one sample every clock cycle unless the sample channel stalls;
// the whole state update of the direction tracker, and the queue write of any result,
// happens in the cycle an item is accepted. A two-entry result queue separates the
// tracker from the result channel, so samples keep flowing while a result waits;
// the sample channel stalls only when both queue entries are held and the result
// channel is not taking one. Threshold writes are taken at any time, one per cycle,
// and belong between data sets while the block is idle.
// Depends on ptd_pkg, ptd_if, ptd_front, ptd_queue and assert_macros.svh.
module peak_trough_detector import ptd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ptd_req_if.sink  req_if,
   ptd_rsp_if.source rsp_if,
   ptd_csr_if.sink  csr_if
);

   logic       queue_space;
   logic       push;
   result_type evt;
   result_type head;

   assign csr_if.ready = 1'b1;

   ptd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_if.valid),
      .csr_data    (csr_if.threshold),
      .req_valid   (req_if.valid),
      .req_sample  (req_if.sample),
      .req_last    (req_if.last_in_set),
      .req_ready   (req_if.ready),
      .queue_space (queue_space),
      .push        (push),
      .evt         (evt)
   );

   ptd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (evt),
      .space     (queue_space),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (head),
      .rsp_ready (rsp_if.ready)
   );

   assign rsp_if.event_kind  = head.kind;
   assign rsp_if.event_index = head.index;
   assign rsp_if.event_value = head.value;
   assign rsp_if.event_count = head.count;

endmodule
